// ===== design/mexp_pkg.sv =====
`timescale 1ns / 1ps

package mexp_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int BIT_INDEX_WIDTH = $clog2(WORD_WIDTH);
   localparam int CSR_INDEX_WIDTH = 1;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [BIT_INDEX_WIDTH-1:0] bit_index_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_EXPONENT = csr_index_type'(0);
   localparam csr_index_type CSR_MODULUS = csr_index_type'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_DOUBLE,
      ST_ADD,
      ST_DONE
   } state_type;

endpackage

// ===== design/modular_exponentiation.sv =====
`timescale 1ns / 1ps

// Modular exponentiation: rsp_result = req_message ^ exponent mod modulus.
// Configuration: csr_write_enable with csr_index (0 exponent, 1 modulus) and
//   csr_write_data writes a register at the clock edge. Write only while idle.
// Request: a word is taken at a clock edge with start high and busy low.
//   busy stays high until the result word has been presented.
// Response: rsp_valid is high for one cycle with rsp_result; it cannot stall.
// Timing: one shared add-compare-subtract unit does one step per cycle.
//   Message reduction runs first, bit by bit. Each modular product takes a
//   step per bit plus one per set bit of the current accumulator. Every
//   exponent bit costs a square, and a set exponent bit also a multiply.
//   A modulus of 0 or 1 skips the computation and answers 0.
// The next request is taken in the cycle after the response strobe.
// Reset: exponent and modulus return to 1 and the block goes idle.

module modular_exponentiation (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  mexp_pkg::word_type      req_message,
   output logic                    rsp_valid,
   output mexp_pkg::word_type      rsp_result,
   input  logic                    csr_write_enable,
   input  mexp_pkg::csr_index_type csr_index,
   input  mexp_pkg::word_type      csr_write_data
);

   import mexp_pkg::*;

   localparam bit_index_type TOP_BIT = bit_index_type'(WORD_WIDTH - 1);

   state_type     state_ff, state_in;
   word_type      exponent_ff, exponent_in;
   word_type      modulus_ff, modulus_in;
   word_type      mod_ff, mod_in;
   word_type      msg_ff, msg_in;
   word_type      base_ff, base_in;
   word_type      acc_ff, acc_in;
   word_type      prod_ff, prod_in;
   bit_index_type bit_ff, bit_in;
   bit_index_type ebit_ff, ebit_in;
   logic          square_ff, square_in;

   word_type         unit_x, unit_y, unit_out;
   logic             unit_cin;
   logic [WORD_WIDTH:0] unit_sum, unit_diff;
   logic             mul_last;
   logic             mul_next;

   // shared unit: (x + y + cin) mod m for x, y < m
   always_comb begin
      unit_x = prod_ff;
      unit_y = prod_ff;
      unit_cin = 1'b0;
      unique case (state_ff)
         ST_REDUCE: unit_cin = msg_ff[bit_ff];
         ST_ADD:    unit_y = square_ff ? acc_ff : base_ff;
         default:   unit_cin = 1'b0;
      endcase
      unit_sum = {1'b0, unit_x} + {1'b0, unit_y} + {{WORD_WIDTH{1'b0}}, unit_cin};
      unit_diff = unit_sum - {1'b0, mod_ff};
      unit_out = (unit_sum >= {1'b0, mod_ff}) ? unit_diff[WORD_WIDTH-1:0]
                                              : unit_sum[WORD_WIDTH-1:0];
   end

   assign mul_last = ((state_ff == ST_DOUBLE) && !acc_ff[bit_ff] && (bit_ff == '0))
                  || ((state_ff == ST_ADD) && (bit_ff == '0));
   assign mul_next = square_ff && exponent_ff[ebit_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (modulus_ff <= word_type'(1)) ? ST_DONE : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (bit_ff == '0) begin
               state_in = ST_DOUBLE;
            end
         end
         ST_DOUBLE, ST_ADD: begin
            priority if (mul_last) begin
               state_in = (!mul_next && (ebit_ff == '0)) ? ST_DONE : ST_DOUBLE;
            end else if ((state_ff == ST_DOUBLE) && acc_ff[bit_ff]) begin
               state_in = ST_ADD;
            end else begin
               state_in = ST_DOUBLE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      rsp_result = acc_ff;
   end

   // datapath
   always_comb begin
      exponent_in = exponent_ff;
      modulus_in = modulus_ff;
      mod_in = mod_ff;
      msg_in = msg_ff;
      base_in = base_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      bit_in = bit_ff;
      ebit_in = ebit_ff;
      square_in = square_ff;

      if (csr_write_enable) begin
         priority if (csr_index == CSR_EXPONENT) begin
            exponent_in = csr_write_data;
         end else if (csr_index == CSR_MODULUS) begin
            modulus_in = csr_write_data;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               msg_in = req_message;
               mod_in = modulus_ff;
               prod_in = '0;
               acc_in = '0;
               bit_in = TOP_BIT;
            end
         end
         ST_REDUCE: begin
            prod_in = unit_out;
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               base_in = unit_out;
               acc_in = word_type'(1);
               prod_in = '0;
               bit_in = TOP_BIT;
               ebit_in = TOP_BIT;
               square_in = 1'b1;
            end
         end
         ST_DOUBLE, ST_ADD: begin
            prod_in = unit_out;
            if (!((state_ff == ST_DOUBLE) && acc_ff[bit_ff])) begin
               bit_in = bit_ff - 1'b1;
            end
            if (mul_last) begin
               acc_in = unit_out;
               prod_in = '0;
               bit_in = TOP_BIT;
               if (mul_next) begin
                  square_in = 1'b0;
               end else begin
                  square_in = 1'b1;
                  ebit_in = ebit_ff - 1'b1;
               end
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         exponent_ff <= word_type'(1);
         modulus_ff <= word_type'(1);
      end else begin
         state_ff <= state_in;
         exponent_ff <= exponent_in;
         modulus_ff <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      mod_ff <= mod_in;
      msg_ff <= msg_in;
      base_ff <= base_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      bit_ff <= bit_in;
      ebit_ff <= ebit_in;
      square_ff <= square_in;
   end

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken without going busy");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((mod_ff <= word_type'(1)) && (rsp_result == '0))
                 || (rsp_result < mod_ff))
      else $error("result not reduced");

   a_prod_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DOUBLE) || (state_ff == ST_ADD))
         |-> (prod_ff < mod_ff) && (acc_ff < mod_ff) && (base_ff < mod_ff))
      else $error("operand not reduced");

endmodule
